@@ hw/rtl/apra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apra_pkg
// Shared constants, register indexes and state type of the aligned page
// region allocator.
// ----------------------------------------------------------------------------
package apra_pkg;

    localparam int MAX_PAGES  = 256;
    localparam int ROW_BITS   = 16;
    localparam int MAP_ROWS   = MAX_PAGES / ROW_BITS;
    localparam int ROW_AW     = $clog2(MAP_ROWS);
    localparam int COL_AW     = $clog2(ROW_BITS);
    localparam int PAGE_AW    = $clog2(MAX_PAGES);
    localparam int COUNT_W    = PAGE_AW + 1;
    localparam int MAX_ORDER  = PAGE_AW;

    localparam int ADDR_W     = 32;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int VPAGE_W    = 20;   // 32-bit byte value over a 4 KiB minimum page
    localparam int ORDER_W    = 5;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd20;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 2'd2;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_RESP
    } state_t;

    // bit length of a page-count-minus-one value
    function automatic logic [ORDER_W-1:0] bit_length(input logic [VPAGE_W-1:0] v);
        logic [ORDER_W-1:0] n;
        n = '0;
        for (int i = 0; i < VPAGE_W; i++) begin
            if (v[i]) begin
                n = ORDER_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ hw/rtl/aligned_page_region_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_page_region_allocator_unit
// Power-of-two aligned page region allocator over a one-bit-per-page map.
// ----------------------------------------------------------------------------
// Flow: zero size, oversize or out-of-pool release go straight to the response;
//   release reads and writes each map row touched (up to 16 rows); allocate
//   reads and checks each map row scanned, then reads and writes each row
//   marked. One request in flight at a time.
// Map access: bounded by the single-port page map: every scanned or updated
//   row costs one read and one check or write.
// Reset: aresetn (synchronous, active low) resets the FSM and config registers
//   (shift to SHIFT_MIN), clears the per-row valid bits: the whole map reads free.
// ----------------------------------------------------------------------------
module aligned_page_region_allocator_unit
    import apra_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata,

    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [ADDR_W-1:0]    s_request_size,
    input  logic [ADDR_W-1:0]    s_release_addr,

    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_region_addr,
    output logic                 m_ok
);

    // ------------------------------------------------------------------
    // Configuration registers, stored already clamped to their legal range
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  base_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [SHIFT_W-1:0] cfg_shift;
    logic [COUNT_W-1:0] cfg_count;

    assign cfg_shift = (cfg_wdata[SHIFT_W-1:0] < SHIFT_MIN) ? SHIFT_MIN :
                       (cfg_wdata[SHIFT_W-1:0] > SHIFT_MAX) ? SHIFT_MAX :
                       cfg_wdata[SHIFT_W-1:0];
    assign cfg_count = (cfg_wdata[COUNT_W-1:0] > COUNT_W'(MAX_PAGES)) ?
                       COUNT_W'(MAX_PAGES) : cfg_wdata[COUNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            shift_reg <= SHIFT_MIN;
            count_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_POOL_BASE:  base_reg  <= cfg_wdata;
                REG_PAGE_SHIFT: shift_reg <= cfg_shift;
                REG_PAGE_COUNT: count_reg <= cfg_count;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Page map: MAP_ROWS rows of ROW_BITS pages, one read or one write a
    // cycle, registered read. Per-row valid bits stand in for a clear.
    // ------------------------------------------------------------------
    logic [ROW_BITS-1:0] map_mem [MAP_ROWS];
    logic [MAP_ROWS-1:0] row_vld_reg;
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                rd_vld_reg;

    logic                mem_rd_en;
    logic                mem_wr_en;
    logic [ROW_BITS-1:0] mem_wr_data;
    logic [ROW_BITS-1:0] row_data;

    // ------------------------------------------------------------------
    // Request and sequencer registers
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic               rel_reg, rel_next;
    logic               zero_reg, zero_next;
    logic [VPAGE_W-1:0] v_reg, v_next;           // pages - 1
    logic [VPAGE_W-1:0] pageno_reg, pageno_next; // release page number
    logic [3:0]         order_reg, order_next;
    logic [COUNT_W-1:0] cand_reg, cand_next;     // candidate start page
    logic [ROW_AW-1:0]  row_reg, row_next;
    logic [PAGE_AW-1:0] lo_reg, lo_next;         // update range [lo, hi)
    logic [COUNT_W-1:0] hi_reg, hi_next;
    logic               set_reg, set_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic               res_ok_reg, res_ok_next;
    logic               m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]  m_addr_reg, m_addr_next;
    logic               m_ok_reg, m_ok_next;

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            rd_data_reg <= map_mem[row_reg];
        end
        if (mem_wr_en) begin
            map_mem[row_reg] <= mem_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (mem_rd_en) begin
                rd_vld_reg <= row_vld_reg[row_reg];
            end
            if (mem_wr_en) begin
                row_vld_reg[row_reg] <= 1'b1;
            end
        end
    end

    assign row_data = rd_vld_reg ? rd_data_reg : '0;

    // ------------------------------------------------------------------
    // Decode of the order once the page count is known
    // ------------------------------------------------------------------
    logic [ORDER_W-1:0] prep_order;
    logic               prep_big;
    logic [VPAGE_W:0]   prep_len;
    logic [VPAGE_W:0]   rel_end;
    logic               rel_fit;

    assign prep_order = bit_length(v_reg);
    assign prep_big   = prep_order > ORDER_W'(MAX_ORDER);
    assign prep_len   = (VPAGE_W+1)'(1) << prep_order;
    assign rel_end    = {1'b0, pageno_reg} + prep_len;
    assign rel_fit    = rel_end <= (VPAGE_W+1)'(count_reg);

    // ------------------------------------------------------------------
    // Scan support
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] len_w;
    logic               small_mode;   // region fits inside one row
    logic [COUNT_W-1:0] step_w;
    logic [COUNT_W:0]   cand_end;
    logic               scan_fit;
    logic [COUNT_W-1:0] cand_adv;
    logic [ROW_AW-1:0]  last_row;
    logic               row_free;
    logic [ROW_BITS-1:0] len_mask;
    logic               slot_found;
    logic [COL_AW-1:0]  slot_idx;

    assign len_w      = COUNT_W'(1) << order_reg;
    assign small_mode = order_reg <= 4'(COL_AW);
    assign step_w     = small_mode ? COUNT_W'(ROW_BITS) : len_w;
    assign cand_end   = {1'b0, cand_reg} + {1'b0, len_w};
    assign scan_fit   = cand_end <= {1'b0, count_reg};
    assign cand_adv   = cand_reg + step_w;
    assign last_row   = ROW_AW'((cand_end - (COUNT_W+1)'(1)) >> COL_AW);
    assign row_free   = row_data == '0;
    assign len_mask   = ROW_BITS'(((ROW_BITS+1)'(1) << len_w[COL_AW:0]) - (ROW_BITS+1)'(1));

    // first aligned free slot in the row whose end stays inside the pool
    always_comb begin
        logic [ROW_BITS-1:0] smask;
        logic                aligned;
        logic [COUNT_W:0]    send;
        slot_found = 1'b0;
        slot_idx   = '0;
        for (int j = ROW_BITS - 1; j >= 0; j--) begin
            smask   = len_mask << j;
            aligned = (COL_AW'(j) & COL_AW'(len_w - COUNT_W'(1))) == '0;
            send    = {1'b0, cand_reg} + (COUNT_W+1)'(j) + {1'b0, len_w};
            if (aligned && ((row_data & smask) == '0) && (send <= {1'b0, count_reg})) begin
                slot_found = 1'b1;
                slot_idx   = COL_AW'(j);
            end
        end
    end

    // ------------------------------------------------------------------
    // Row update: set or clear the pages of [lo, hi) in the current row
    // ------------------------------------------------------------------
    logic [ROW_BITS-1:0] upd_mask;
    logic [COUNT_W-1:0]  hi_m1;
    logic                upd_last;
    logic [ADDR_W-1:0]   alloc_addr;

    always_comb begin
        logic [COUNT_W-1:0] page;
        for (int j = 0; j < ROW_BITS; j++) begin
            page        = {1'b0, row_reg, COL_AW'(j)};
            upd_mask[j] = (page >= {1'b0, lo_reg}) && (page < hi_reg);
        end
    end

    assign mem_wr_data = set_reg ? (row_data | upd_mask) : (row_data & ~upd_mask);
    assign hi_m1       = hi_reg - COUNT_W'(1);
    assign upd_last    = row_reg == hi_m1[PAGE_AW-1:COL_AW];
    assign alloc_addr  = base_reg + (ADDR_W'(lo_reg) << shift_reg);

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (zero_reg || prep_big) begin
                    state_next = ST_RESP;
                end else if (rel_reg == REQ_RELEASE) begin
                    state_next = rel_fit ? ST_UPD_RD : ST_RESP;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                state_next = scan_fit ? ST_SCAN_CHK : ST_RESP;
            end
            ST_SCAN_CHK: begin
                if (small_mode) begin
                    state_next = slot_found ? ST_UPD_RD : ST_SCAN_RD;
                end else if (row_free && (row_reg == last_row)) begin
                    state_next = ST_UPD_RD;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_UPD_RD: begin
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                if (upd_last) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_UPD_RD;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // FSM: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready   = 1'b0;
        mem_rd_en = 1'b0;
        mem_wr_en = 1'b0;
        case (state_reg)
            ST_IDLE:    s_ready   = 1'b1;
            ST_SCAN_RD: mem_rd_en = scan_fit;
            ST_UPD_RD:  mem_rd_en = 1'b1;
            ST_UPD_WR:  mem_wr_en = 1'b1;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        rel_next      = rel_reg;
        zero_next     = zero_reg;
        v_next        = v_reg;
        pageno_next   = pageno_reg;
        order_next    = order_reg;
        cand_next     = cand_reg;
        row_next      = row_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        set_next      = set_reg;
        res_addr_next = res_addr_reg;
        res_ok_next   = res_ok_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_addr_next   = m_addr_reg;
        m_ok_next     = m_ok_reg;

        case (state_reg)
            ST_IDLE: begin
                // latch the transfer; pages - 1 = (size - 1) >> shift for size > 0
                rel_next    = s_req_type;
                zero_next   = s_request_size == '0;
                v_next      = VPAGE_W'((s_request_size - ADDR_W'(1)) >> shift_reg);
                pageno_next = VPAGE_W'((s_release_addr - base_reg) >> shift_reg);
            end
            ST_PREP: begin
                order_next    = prep_order[3:0];
                res_addr_next = '0;
                res_ok_next   = 1'b0;
                cand_next     = '0;
                row_next      = '0;
                if (rel_reg == REQ_RELEASE) begin
                    lo_next  = pageno_reg[PAGE_AW-1:0];
                    hi_next  = COUNT_W'(rel_end);
                    set_next = 1'b0;
                    row_next = pageno_reg[PAGE_AW-1:COL_AW];
                end
            end
            ST_SCAN_CHK: begin
                if (small_mode && slot_found) begin
                    lo_next  = cand_reg[PAGE_AW-1:0] | PAGE_AW'(slot_idx);
                    hi_next  = COUNT_W'(cand_reg[PAGE_AW-1:0] | PAGE_AW'(slot_idx)) + len_w;
                    set_next = 1'b1;
                end else if (!small_mode && row_free && (row_reg == last_row)) begin
                    lo_next  = cand_reg[PAGE_AW-1:0];
                    hi_next  = COUNT_W'(cand_end);
                    set_next = 1'b1;
                    row_next = cand_reg[PAGE_AW-1:COL_AW];
                end else if (small_mode || !row_free) begin
                    // skip to the next aligned candidate
                    cand_next = cand_adv;
                    row_next  = cand_adv[PAGE_AW-1:COL_AW];
                end else begin
                    row_next = row_reg + ROW_AW'(1);
                end
            end
            ST_UPD_WR: begin
                if (upd_last) begin
                    res_ok_next   = 1'b1;
                    res_addr_next = set_reg ? alloc_addr : '0;
                end else begin
                    row_next = row_reg + ROW_AW'(1);
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = res_addr_reg;
                    m_ok_next    = res_ok_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rel_reg      <= rel_next;
        zero_reg     <= zero_next;
        v_reg        <= v_next;
        pageno_reg   <= pageno_next;
        order_reg    <= order_next;
        cand_reg     <= cand_next;
        row_reg      <= row_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        set_reg      <= set_next;
        res_addr_reg <= res_addr_next;
        res_ok_reg   <= res_ok_next;
        m_addr_reg   <= m_addr_next;
        m_ok_reg     <= m_ok_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_region_addr = m_addr_reg;
    assign m_ok          = m_ok_reg;

endmodule
